[hdl/kvt_pkg.sv]
// Package for the keyed variable table: payload structs, operation and
// status codes, controller states and default sizes. No dependencies.
package kvt_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_KEY_WIDTH   = 32;

  localparam int VALUE_WIDTH = 64;
  localparam int TYPE_WIDTH  = 2;

  localparam logic [2:0]             TYPE_NONE  = 3'd4;
  localparam logic [VALUE_WIDTH-1:0] MISS_VALUE = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_HIT       = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [31:0]            key;
    logic [VALUE_WIDTH-1:0] value;
    logic [TYPE_WIDTH-1:0]  value_type;
  } kvt_req_t;

  typedef struct packed {
    logic                   found;
    logic [VALUE_WIDTH-1:0] result_value;
    logic [2:0]             result_type;
    logic [2:0]             status;
  } kvt_rsp_t;

endpackage

[hdl/kvt_req_if.sv]
// Request channel of the keyed variable table: valid, ready and one operation.
// Depends on kvt_pkg.
interface kvt_req_if import kvt_pkg::*; ();
  logic     valid;
  logic     ready;
  kvt_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/kvt_rsp_if.sv]
// Response channel of the keyed variable table: valid, ready and one result.
// Depends on kvt_pkg.
interface kvt_rsp_if import kvt_pkg::*; ();
  logic     valid;
  logic     ready;
  kvt_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/keyed_variable_table_top.sv]
// Top level of the keyed variable table: controller, tag and value memories.
// Depends on kvt_pkg, kvt_req_if and kvt_rsp_if.
//
// Usage: each transfer on req carries one operation (insert or update, lookup,
// delete) with a key, a 64-bit value and a type tag. Each operation produces
// exactly one transfer on rsp with found, result_value, result_type and status.
// The table lives in two single-port-style synchronous memories: a tag memory
// holding {valid, type, key} and a value memory holding the 64-bit data.
// An operation scans the tag memory one entry per cycle, stopping at the first
// matching key while noting the lowest free slot, then writes back or reads the
// value in the action state and loads the response register in the response state.
// One operation is in flight at a time; the next one is accepted as soon as
// the response register is loaded, even while that response still waits.
// If the receiver stalls, the finished result is held and the block waits
// before loading a new one. After reset the tag memory is swept to clear
// all valid flags, with req.ready low.
module keyed_variable_table_top import kvt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic clk,
  input  logic rst,
  kvt_req_if.sink   req,
  kvt_rsp_if.source rsp
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TAG_W = 1 + TYPE_WIDTH + KEY_WIDTH;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(TABLE_DEPTH);

  // Controller state.
  state_t state, state_next;

  // Captured operation.
  kvt_req_t             req_q;
  logic [KEY_WIDTH-1:0] key_q;

  // Scan bookkeeping: cnt is the next address to read (also the clear
  // pointer), chk_* describes the tag word that arrives this cycle.
  logic [AW:0]           cnt;
  logic                  chk_valid;
  logic [AW-1:0]         chk_idx;
  logic                  hit;
  logic [AW-1:0]         hit_idx;
  logic [TYPE_WIDTH-1:0] hit_type;
  logic                  free_ok;
  logic [AW-1:0]         free_idx;

  // Tag memory.
  logic [TAG_W-1:0] tag_mem [TABLE_DEPTH];
  logic [TAG_W-1:0] tag_rdata;
  logic             tag_re;
  logic             tag_we;
  logic [AW-1:0]    tag_waddr;
  logic [TAG_W-1:0] tag_wdata;

  // Value memory.
  logic [VALUE_WIDTH-1:0] val_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic                   val_re;
  logic                   val_we;
  logic [AW-1:0]          val_addr;

  // Result decided in the action cycle, completed in the response cycle.
  logic       res_found, res_found_next;
  logic [2:0] res_type, res_type_next;
  status_t    res_status, res_status_next;
  logic       res_sel, res_sel_next;
  logic       res_miss, res_miss_next;

  // Response register.
  logic     out_valid;
  kvt_rsp_t out_data;
  logic     out_load;

  // Decoded tag word under test.
  logic                  t_valid;
  logic [TYPE_WIDTH-1:0] t_type;
  logic [KEY_WIDTH-1:0]  t_key;
  logic                  match_now;
  logic                  free_now;
  logic                  scan_done;
  logic                  accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Keys narrower than the port use its low bits; wider keys are zero-extended.
  assign key_q = KEY_WIDTH'(req_q.key);

  assign t_valid   = tag_rdata[TAG_W-1];
  assign t_type    = tag_rdata[KEY_WIDTH +: TYPE_WIDTH];
  assign t_key     = tag_rdata[KEY_WIDTH-1:0];
  assign match_now = chk_valid && t_valid && (t_key == key_q);
  assign free_now  = chk_valid && !t_valid;
  assign scan_done = match_now || (chk_valid && (chk_idx == LAST_IDX));
  assign tag_re    = (state == S_SCAN) && (cnt < DEPTH_CNT);
  assign out_load  = (state == S_RESP) && (!out_valid || rsp.ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (cnt[AW-1:0] == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory controls and result decode.
  always_comb begin
    tag_we          = 1'b0;
    tag_waddr       = cnt[AW-1:0];
    tag_wdata       = '0;
    val_we          = 1'b0;
    val_re          = 1'b0;
    val_addr        = hit_idx;
    res_found_next  = res_found;
    res_type_next   = res_type;
    res_status_next = res_status;
    res_sel_next    = res_sel;
    res_miss_next   = res_miss;
    case (state)
      S_CLEAR: begin
        tag_we = 1'b1;
      end
      S_ACT: begin
        res_found_next  = 1'b0;
        res_type_next   = TYPE_NONE;
        res_status_next = ST_NOT_FOUND;
        res_sel_next    = 1'b0;
        res_miss_next   = 1'b0;
        case (req_q.op)
          OP_INSERT: begin
            if (hit) begin
              val_we          = 1'b1;
              res_found_next  = 1'b1;
              res_status_next = ST_UPDATED;
            end else if (free_ok) begin
              tag_we          = 1'b1;
              tag_waddr       = free_idx;
              tag_wdata       = {1'b1, req_q.value_type, key_q};
              val_we          = 1'b1;
              val_addr        = free_idx;
              res_status_next = ST_INSERTED;
            end else begin
              res_status_next = ST_FULL;
            end
          end
          OP_LOOKUP: begin
            if (hit) begin
              val_re          = 1'b1;
              res_found_next  = 1'b1;
              res_type_next   = {1'b0, hit_type};
              res_status_next = ST_HIT;
              res_sel_next    = 1'b1;
            end else begin
              res_miss_next = 1'b1;
            end
          end
          OP_DELETE: begin
            if (hit) begin
              // Clearing the valid flag is enough; key and type are dead.
              tag_we          = 1'b1;
              tag_waddr       = hit_idx;
              tag_wdata       = {1'b0, req_q.value_type, key_q};
              res_found_next  = 1'b1;
              res_status_next = ST_DELETED;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Tag memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_rdata <= tag_mem[cnt[AW-1:0]];
    end
  end

  // Value memory: one shared address, registered read data held between reads.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_addr] <= req_q.value;
    end
    if (val_re) begin
      val_rdata <= val_mem[val_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      chk_valid <= 1'b0;
      hit       <= 1'b0;
      free_ok   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          cnt <= (cnt[AW-1:0] == LAST_IDX) ? '0 : cnt + 1'b1;
        end
        S_IDLE: begin
          cnt       <= '0;
          chk_valid <= 1'b0;
          hit       <= 1'b0;
          free_ok   <= 1'b0;
        end
        S_SCAN: begin
          chk_valid <= tag_re && !scan_done;
          if (tag_re) begin
            cnt <= cnt + 1'b1;
          end
          if (match_now) begin
            hit <= 1'b1;
          end
          if (free_now && !free_ok) begin
            free_ok <= 1'b1;
          end
        end
        default: begin
          chk_valid <= 1'b0;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req.data;
    end
    if (tag_re) begin
      chk_idx <= cnt[AW-1:0];
    end
    if (match_now) begin
      hit_idx  <= chk_idx;
      hit_type <= t_type;
    end
    if (free_now && !free_ok) begin
      free_idx <= chk_idx;
    end
    res_found  <= res_found_next;
    res_type   <= res_type_next;
    res_status <= res_status_next;
    res_sel    <= res_sel_next;
    res_miss   <= res_miss_next;
    if (out_load) begin
      out_data.found       <= res_found;
      out_data.result_type <= res_type;
      out_data.status      <= res_status;
      if (res_sel) begin
        out_data.result_value <= val_rdata;
      end else if (res_miss) begin
        out_data.result_value <= MISS_VALUE;
      end else begin
        out_data.result_value <= '0;
      end
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for keyed_variable_table_top: directed and random table operations,
// each response predicted by a behavioral copy of the table and checked in order.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if and keyed_variable_table_top.
module tb;
  import kvt_pkg::*;

  // The block is built with its default sizes, so the scoreboard model uses the same ones.
  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int KEY_W = DEF_KEY_WIDTH;
  localparam logic [31:0] KEY_MASK = 32'hFFFF_FFFF >> (32 - KEY_W);

  // The fourth operation code has no name in the package; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int N_RANDOM     = 1600;
  localparam int KEY_POOL     = 24;          // a little larger than the table, so it fills up
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  // The slowest item in the block scans the whole table. A 72 percent receiver stall or a
  // 36 percent sender gap adds only modest delay on average, so CYCLE_LIMIT leaves a wide margin.
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;

  kvt_req_if req_if ();
  kvt_rsp_if rsp_if ();

  keyed_variable_table_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #1 clk = ~clk;

  // Operations waiting to be driven, and the responses that accepted operations must produce.
  kvt_req_t pending_ops[$];
  kvt_rsp_t expected_rsps[$];

  int unsigned cycles    = 0;
  int          err_count = 0;
  int          sent_count = 0;
  int          total_ops  = 1;

  // Scoreboard copy of the table contents.
  logic                   tbl_valid [DEPTH];
  logic [31:0]            tbl_key   [DEPTH];
  logic [VALUE_WIDTH-1:0] tbl_value [DEPTH];
  logic [TYPE_WIDTH-1:0]  tbl_type  [DEPTH];

  // The run has three stall patterns in sequence. First the receiver stalls more often than
  // the sender idles. Then the two rates swap. In the last third neither side holds back.
  function automatic int stall_phase();
    return (sent_count * 3) / total_ops;
  endfunction

  function automatic int tx_idle_pct();
    case (stall_phase())
      0:       return 36;
      1:       return 72;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (stall_phase())
      0:       return 72;
      1:       return 36;
      default: return 0;
    endcase
  endfunction

  // Applies one operation to the scoreboard table and returns the response it must produce.
  // Both the matching slot and the lowest free slot are found in one pass, so a new key
  // always lands in the lowest free slot. The last slot is searched like any other.
  function automatic kvt_rsp_t apply_op(kvt_req_t r);
    kvt_rsp_t    rsp;
    logic [31:0] k;
    int          hit;
    int          free;
    k    = r.key & KEY_MASK;
    hit  = -1;
    free = -1;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == k) hit = i;
      if (!tbl_valid[i]) free = i;
    end
    rsp.found        = 1'b0;
    rsp.result_value = '0;
    rsp.result_type  = TYPE_NONE;
    rsp.status       = ST_NOT_FOUND;
    case (r.op)
      OP_INSERT: begin
        if (hit >= 0) begin
          // An update replaces only the value. The type stored at insert time stays.
          tbl_value[hit] = r.value;
          rsp.found      = 1'b1;
          rsp.status     = ST_UPDATED;
        end else if (free >= 0) begin
          tbl_valid[free] = 1'b1;
          tbl_key[free]   = k;
          tbl_value[free] = r.value;
          tbl_type[free]  = r.value_type;
          rsp.status      = ST_INSERTED;
        end else begin
          rsp.status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) begin
          rsp.found        = 1'b1;
          rsp.result_value = tbl_value[hit];
          rsp.result_type  = {1'b0, tbl_type[hit]};
          rsp.status       = ST_HIT;
        end else begin
          rsp.result_value = MISS_VALUE;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          rsp.found      = 1'b1;
          rsp.status     = ST_DELETED;
        end
      end
      default: ;  // The unused code changes nothing and answers as a plain miss.
    endcase
    return rsp;
  endfunction

  task automatic queue_op(logic [1:0] op_code, logic [31:0] key, logic [63:0] value,
                          logic [1:0] vtype);
    kvt_req_t item;
    item.op         = op_code;
    item.key        = key;
    item.value      = value;
    item.value_type = vtype;
    pending_ops.push_back(item);
  endtask

  task automatic flag_error(string what);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("tb: mismatch %0d at cycle %0d: %s", err_count, cycles, what);
    end
  endtask

  // Request driver. A new operation may go out once the current one has made its transfer
  // or when the bus is empty. Valid gets at most one assignment per edge, so it stays high
  // across back-to-back transfers.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
        req_if.data  <= pending_ops.pop_front();
        req_if.valid <= 1'b1;
        sent_count   <= sent_count + 1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response receiver. It drops ready at random according to the current stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // Monitor. Values are sampled at the edge before any of this edge's updates land. A response
  // is checked against the oldest prediction. An accepted request is predicted right away.
  // A request's own response can never arrive on the edge that accepts it.
  always @(posedge clk) begin
    kvt_rsp_t want;
    kvt_rsp_t got;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (expected_rsps.size() == 0) begin
          flag_error($sformatf("response with none expected: found=%0b value=%h type=%0d st=%0d",
                               got.found, got.result_value, got.result_type, got.status));
        end else begin
          want = expected_rsps.pop_front();
          if (got.found !== want.found || got.result_value !== want.result_value ||
              got.result_type !== want.result_type || got.status !== want.status) begin
            flag_error($sformatf(
              "exp found=%0b value=%h type=%0d st=%0d, got found=%0b value=%h type=%0d st=%0d",
              want.found, want.result_value, want.result_type, want.status,
              got.found, got.result_value, got.result_type, got.status));
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(apply_op(req_if.data));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] key_pool [KEY_POOL];
    logic [1:0]  op_code;
    logic [31:0] key;
    int          sel;
    int          ins_pct;
    int          del_pct;

    clk          = 1'b0;
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;

    // Directed part. Lookup and delete on the empty table, then the extreme keys and values.
    // An update must keep the original type tag. The unused opcode follows.
    queue_op(OP_LOOKUP, 32'h0000_0000, '0, 2'd0);
    queue_op(OP_DELETE, 32'hFFFF_FFFF, '1, 2'd3);
    queue_op(OP_INSERT, 32'h0000_0000, 64'h0, 2'd0);
    queue_op(OP_INSERT, 32'hFFFF_FFFF, '1, 2'd3);
    queue_op(OP_INSERT, 32'h0000_0000, 64'h8000_0000_0000_0001, 2'd2);
    queue_op(OP_LOOKUP, 32'h0000_0000, '1, 2'd1);
    queue_op(OP_LOOKUP, 32'hFFFF_FFFF, '0, 2'd0);
    queue_op(OP_UNUSED, 32'h0000_0000, '1, 2'd1);
    // Fill the remaining slots. Then one more insert hits a full table.
    for (int i = 2; i < DEPTH; i++) begin
      queue_op(OP_INSERT, 32'h0000_0100 + i, {$urandom, $urandom}, i[1:0]);
    end
    queue_op(OP_INSERT, 32'h5A5A_5A5A, '1, 2'd1);
    // The last slot must be found by lookup and delete alike.
    queue_op(OP_LOOKUP, 32'h0000_0100 + DEPTH - 1, '0, 2'd0);
    queue_op(OP_DELETE, 32'h0000_0100 + DEPTH - 1, '0, 2'd0);
    // With slot 0 and the last slot free, a new key must take slot 0.
    queue_op(OP_DELETE, 32'h0000_0000, '0, 2'd0);
    queue_op(OP_INSERT, 32'hA5A5_A5A5, 64'h5555_AAAA_5555_AAAA, 2'd3);
    queue_op(OP_LOOKUP, 32'hA5A5_A5A5, '0, 2'd0);

    // Random part. Most keys come from a small pool, so hits, updates and full inserts are
    // common. A tenth are fresh 32-bit keys that mostly miss. The insert/delete balance
    // alternates so the table both fills up and drains.
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    for (int n = 0; n < N_RANDOM; n++) begin
      ins_pct = ((n / 200) % 2 == 0) ? 45 : 25;
      del_pct = ((n / 200) % 2 == 0) ? 15 : 35;
      sel     = $urandom_range(99);
      if (sel < ins_pct) begin
        op_code = OP_INSERT;
      end else if (sel < ins_pct + del_pct) begin
        op_code = OP_DELETE;
      end else if (sel < 95) begin
        op_code = OP_LOOKUP;
      end else begin
        op_code = OP_UNUSED;
      end
      key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(KEY_POOL - 1)];
      queue_op(op_code, key, {$urandom, $urandom}, 2'($urandom_range(3)));
    end
    total_ops = pending_ops.size();

    // The block clears its tag memory after reset with ready low, so the driver simply waits
    // for ready.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait until every operation has been sent and every predicted response has arrived.
    // Then idle long enough for a stray extra response to show up.
    do @(posedge clk);
    while (pending_ops.size() != 0 || req_if.valid || expected_rsps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && expected_rsps.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
